### sv/e2efc_pkg.sv
// shared types, constants and crc helper for the e2e frame checker
// no dependencies; imported by e2efc_crc8 and e2e_frame_checker_top
`timescale 1ns / 1ps

package e2efc_pkg;

    // frame layout
    localparam int FRAME_BYTES      = 8;
    localparam int CRC_POSITION     = 7;
    localparam int COUNTER_POSITION = 6;

    // field widths
    localparam int FRAME_W   = 64;
    localparam int LEN_W     = 4;
    localparam int CNT_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int GAP_W     = 4;

    // crc-8 sae j1850 form
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] CRC_POLY   = 8'h1D;
    localparam logic [7:0] CRC_XOROUT = 8'hFF;

    // register map
    localparam logic REG_MAX_GAP     = 1'b0;
    localparam logic [GAP_W-1:0] GAP_RESET = 4'd2;

    // item kinds
    localparam logic KIND_CHECK  = 1'b0;
    localparam logic KIND_REINIT = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_SOME_LOST = 3'd1,
        ST_INITIAL   = 3'd2,
        ST_REPEATED  = 3'd3,
        ST_WRONG_SEQ = 3'd4,
        ST_CRC_ERR   = 3'd5,
        ST_LEN_ERR   = 3'd6,
        ST_REINIT    = 3'd7
    } t_status;

    // crc check result handed to the top level
    typedef struct packed {
        logic             crc_ok;
        logic [CNT_W-1:0] counter;
    } t_chk;

    // one byte through the msb-first crc register
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

### sv/e2efc_crc8.sv
// crc-8 check over the leading frame bytes and counter nibble extraction
// depends on e2efc_pkg
`timescale 1ns / 1ps

module e2efc_crc8
    import e2efc_pkg::*;
(
    input  logic [FRAME_W-1:0] i_frame,
    output t_chk               o_chk
);

    logic [7:0] w_crc [0:CRC_POSITION];
    logic [7:0] w_crc_final;

    // unrolled byte-wise crc chain
    assign w_crc[0] = CRC_INIT;

    for (genvar g = 0; g < CRC_POSITION; g++) begin : g_byte
        assign w_crc[g+1] = crc8_byte(w_crc[g], i_frame[8*g +: 8]);
    end

    assign w_crc_final = w_crc[CRC_POSITION] ^ CRC_XOROUT;

    // compare against the transmitted crc byte, pick the counter nibble
    assign o_chk.crc_ok  = (w_crc_final == i_frame[8*CRC_POSITION +: 8]);
    assign o_chk.counter = i_frame[8*COUNTER_POSITION +: CNT_W];

endmodule

### sv/e2e_frame_checker_top.sv
// e2e frame checker: an accepted input beat passes the input register, then the
// result register; one frame accepted every cycle while m_axis_tready is not held low,
// and a waiting result does not block the next beat while the input stage is free.
// synchronous active-low reset: empties both stages, clears the receiver
// state (unsynchronised, last counter 0) and sets max_counter_gap to 2
`timescale 1ns / 1ps

module e2e_frame_checker_top
    import e2efc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // [63:0] frame_bytes, [67:64] frame_length, zero pad
    input  logic [0:0]  s_axis_tuser,  // [0] kind
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [2:0] status, [6:3] received_counter, zero pad
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // input stage
    logic               r_in_valid;
    logic               r_kind;
    logic [FRAME_W-1:0] r_frame;
    logic [LEN_W-1:0]   r_len;

    // result stage
    logic               r_out_valid;
    t_status            r_status;
    logic [CNT_W-1:0]   r_counter;

    // receiver state and configuration
    logic               r_sync;
    logic [CNT_W-1:0]   r_last_cnt;
    logic [GAP_W-1:0]   r_max_gap;

    logic               w_in_beat;
    logic               w_move;
    logic               w_out_free;
    logic               w_cfg_wr;
    t_chk               w_chk;
    t_status            n_status;
    logic [CNT_W-1:0]   n_counter;
    logic               n_sync;
    logic [CNT_W-1:0]   n_last_cnt;
    logic [CNT_W-1:0]   w_delta;

    // handshake
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_move        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_move;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_beat) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_kind  <= s_axis_tuser[0];
            r_frame <= s_axis_tdata[FRAME_W-1:0];
            r_len   <= s_axis_tdata[FRAME_W +: LEN_W];
        end
    end

    // crc and counter extraction
    e2efc_crc8 u_crc8 (
        .i_frame (r_frame),
        .o_chk   (w_chk)
    );

    assign w_delta = w_chk.counter - r_last_cnt;

    // classification and next receiver state
    always_comb begin
        n_status   = ST_OK;
        n_counter  = '0;
        n_sync     = r_sync;
        n_last_cnt = r_last_cnt;
        if (r_kind == KIND_REINIT) begin
            n_status   = ST_REINIT;
            n_sync     = 1'b0;
            n_last_cnt = '0;
        end else if (r_len < LEN_W'(FRAME_BYTES)) begin
            n_status = ST_LEN_ERR;
        end else if (!w_chk.crc_ok) begin
            n_status = ST_CRC_ERR;
        end else begin
            n_counter = w_chk.counter;
            if (!r_sync) begin
                n_status   = ST_INITIAL;
                n_sync     = 1'b1;
                n_last_cnt = w_chk.counter;
            end else if (w_delta == '0) begin
                n_status = ST_REPEATED;
            end else begin
                n_last_cnt = w_chk.counter;
                if (w_delta == CNT_W'(1)) begin
                    n_status = ST_OK;
                end else if (w_delta <= r_max_gap) begin
                    n_status = ST_SOME_LOST;
                end else begin
                    n_status = ST_WRONG_SEQ;
                end
            end
        end
    end

    // receiver state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync     <= 1'b0;
            r_last_cnt <= '0;
        end else if (w_move) begin
            r_sync     <= n_sync;
            r_last_cnt <= n_last_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_status  <= n_status;
            r_counter <= n_counter;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_counter, r_status};

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_GAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gap <= GAP_RESET;
        end else if (w_cfg_wr) begin
            r_max_gap <= pwdata[GAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_GAP) ? {{(32-GAP_W){1'b0}}, r_max_gap} : '0;

`ifndef SYNTHESIS
    // a reinit beat leaves the receiver unsynchronised
    a_reinit_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_kind == KIND_REINIT) |=> (!r_sync && r_last_cnt == '0))
        else $error("receiver state not cleared after reinit");

    // initial status only while unsynchronised
    a_initial_unsync : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && n_status == ST_INITIAL) |-> !r_sync)
        else $error("initial status on a synchronised receiver");

    // error and reinit results carry a zero counter
    a_err_zero_cnt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_CRC_ERR || r_status == ST_LEN_ERR ||
                         r_status == ST_REINIT)) |-> (r_counter == '0))
        else $error("nonzero counter on an error result");

    // a repeated counter keeps the last counter
    a_repeat_keeps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && n_status == ST_REPEATED) |=> $stable(r_last_cnt))
        else $error("last counter changed on a repeated frame");
`endif

endmodule

### tb/e2e_frame_checker_top_test.sv
// self-checking testbench for e2e_frame_checker_top: frame beats in, verdict beats out
// depends on e2efc_pkg (sv/e2efc_pkg.sv) and the e2e_frame_checker_top rtl
`timescale 1ns / 1ps

module e2e_frame_checker_top_test;
    import e2efc_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_LIMIT = 20000;
    localparam int PHASE_ITEMS = 140;

    // expected verdict for one accepted frame beat
    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] counter;
    } t_verdict;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;  // [63:0] frame_bytes, [67:64] frame_length, zero pad
    logic [0:0]  s_axis_tuser  = '0;  // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [2:0] status, [6:3] received_counter, zero pad
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // shared between the sender and receiver processes
    bit steady        = 1'b0;
    bit hold_request  = 1'b0;

    e2e_frame_checker_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    // crc-8 j1850 over the bytes ahead of the crc byte, msb first
    function automatic logic [7:0] j1850_crc(input logic [FRAME_W-1:0] frame);
        logic [7:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < CRC_POSITION; i++) begin
            crc = crc ^ frame[8*i +: 8];
            for (int b = 0; b < 8; b++) begin
                crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
            end
        end
        return crc ^ CRC_XOROUT;
    endfunction

    // receiver state mirror and the queue of verdicts still to arrive
    class frame_verdict_board;
        logic [GAP_W-1:0] gap_limit;
        logic [CNT_W-1:0] last_cnt;
        bit               synced;
        t_verdict         pending_verdicts[$];
        int               errors;

        function new();
            gap_limit = GAP_RESET;
            last_cnt  = '0;
            synced    = 1'b0;
            errors    = 0;
        endfunction

        function void set_gap(input logic [GAP_W-1:0] value);
            gap_limit = value;
        endfunction

        function void flag_mismatch(input string what, input int exp_val, input int act_val);
            errors++;
            $display("%0t mismatch %s: expected %0d actual %0d", $time, what, exp_val, act_val);
        endfunction

        // work out the verdict of one accepted frame beat
        function void predict_verdict(input logic kind, input logic [FRAME_W-1:0] frame,
                                      input logic [LEN_W-1:0] len);
            t_verdict         v;
            logic [CNT_W-1:0] cnt;
            logic [CNT_W-1:0] cnt_dist;
            v.counter = '0;
            if (kind == KIND_REINIT) begin
                synced   = 1'b0;
                last_cnt = '0;
                v.status = ST_REINIT;
            end else if (len < FRAME_BYTES) begin
                v.status = ST_LEN_ERR;
            end else if (j1850_crc(frame) != frame[8*CRC_POSITION +: 8]) begin
                v.status = ST_CRC_ERR;
            end else begin
                cnt       = frame[8*COUNTER_POSITION +: CNT_W];
                v.counter = cnt;
                cnt_dist  = cnt - last_cnt;
                if (!synced) begin
                    synced   = 1'b1;
                    last_cnt = cnt;
                    v.status = ST_INITIAL;
                end else if (cnt_dist == 0) begin
                    v.status = ST_REPEATED;
                end else begin
                    last_cnt = cnt;
                    if (cnt_dist == 1)
                        v.status = ST_OK;
                    else if (cnt_dist <= gap_limit)
                        v.status = ST_SOME_LOST;
                    else
                        v.status = ST_WRONG_SEQ;
                end
            end
            pending_verdicts.push_back(v);
        endfunction

        // compare one result beat with the oldest verdict
        function void check_result(input logic [7:0] beat);
            t_verdict v;
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t unexpected result beat: expected none actual status %0d counter %0d",
                         $time, beat[2:0], beat[6:3]);
                return;
            end
            v = pending_verdicts.pop_front();
            if (beat[2:0] != v.status)
                flag_mismatch("status", v.status, beat[2:0]);
            if (beat[6:3] != v.counter)
                flag_mismatch("received_counter", v.counter, beat[6:3]);
        endfunction

        function bit drained();
            return pending_verdicts.size() == 0;
        endfunction

        function void report_leftover();
            while (pending_verdicts.size() > 0) begin
                t_verdict v;
                v = pending_verdicts.pop_front();
                errors++;
                $display("%0t missing result: expected status %0d counter %0d actual none",
                         $time, v.status, v.counter);
            end
        endfunction
    endclass

    frame_verdict_board verdicts = new();

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // good frame: base bytes, counter nibble in place, crc byte filled in
    function automatic logic [FRAME_W-1:0] build_frame(input logic [FRAME_W-1:0] base,
                                                       input logic [CNT_W-1:0] cnt);
        logic [FRAME_W-1:0] f;
        f = base;
        f[8*COUNTER_POSITION +: CNT_W] = cnt;
        f[8*CRC_POSITION +: 8] = j1850_crc(f);
        return f;
    endfunction

    function automatic logic [FRAME_W-1:0] rand_frame();
        return {$urandom(), $urandom()};
    endfunction

    // offer one frame beat, hold it until accepted, then maybe drop valid for a gap
    task automatic send_frame(input logic kind, input logic [FRAME_W-1:0] frame,
                              input logic [LEN_W-1:0] len);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0, len, frame};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        verdicts.predict_verdict(kind, frame, len);
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and let every expected verdict come back
    task automatic wait_idle();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (!verdicts.drained() && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup then access, register taken at the access edge
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        verdicts.set_gap(data[GAP_W-1:0]);
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] exp_data);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== exp_data)
            verdicts.flag_mismatch("max_counter_gap readback", exp_data, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one random beat: mostly well-formed counter sequences, the rest noise
    task automatic send_random(inout logic [CNT_W-1:0] seq_cnt);
        int                 r;
        int                 d;
        logic [FRAME_W-1:0] f;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            d = $urandom_range(0, 99);
            if (d < 50)      seq_cnt = seq_cnt + 1;
            else if (d < 60) seq_cnt = seq_cnt;
            else if (d < 80) seq_cnt = seq_cnt + 4'($urandom_range(2, 4));
            else             seq_cnt = seq_cnt + 4'($urandom_range(0, 15));
            send_frame(KIND_CHECK, build_frame(rand_frame(), seq_cnt),
                       4'($urandom_range(FRAME_BYTES, 15)));
        end else if (r < 80) begin
            // one bit flipped anywhere in a good frame
            f = build_frame(rand_frame(), seq_cnt + 1);
            f[$urandom_range(0, FRAME_W-1)] ^= 1'b1;
            send_frame(KIND_CHECK, f, 4'($urandom_range(FRAME_BYTES, 15)));
        end else if (r < 88) begin
            send_frame(KIND_CHECK, build_frame(rand_frame(), seq_cnt + 1),
                       4'($urandom_range(0, FRAME_BYTES-1)));
        end else if (r < 93) begin
            send_frame(KIND_REINIT, rand_frame(), 4'($urandom_range(0, 15)));
        end else begin
            send_frame(1'($urandom_range(0, 1)), rand_frame(), 4'($urandom_range(0, 15)));
        end
    endtask

    // result side: random back-pressure, one long hold on request
    initial begin
        int hold;
        bit ready_next;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                verdicts.check_result(m_axis_tdata);
            if (hold_request) begin
                hold         = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                ready_next = 1'b0;
            end else if (steady || $urandom_range(0, 99) < 70) begin
                ready_next = 1'b1;
            end else begin
                hold       = pick_gap();
                ready_next = (hold == 0);
            end
            m_axis_tready <= ready_next;
        end
    end

    // main sequence
    initial begin
        logic [CNT_W-1:0] seq_cnt;
        logic [GAP_W-1:0] gap_values[6];
        logic [2:0]       gap_addr;
        gap_addr   = 3'(4 * REG_MAX_GAP);
        gap_values = '{4'd15, 4'd0, 4'd1, 4'($urandom_range(0, 15)),
                       4'($urandom_range(2, 14)), 4'($urandom_range(0, 15))};
        seq_cnt    = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_read_check(gap_addr, 32'(GAP_RESET));

        // directed frames, gap register at its reset value
        send_frame(KIND_REINIT, '1, 4'd15);
        send_frame(KIND_CHECK, build_frame(rand_frame(), 4'd3), 4'd7);
        send_frame(KIND_CHECK, '0, 4'd0);
        send_frame(KIND_CHECK, '0, 4'd8);
        send_frame(KIND_CHECK, build_frame(rand_frame(), 4'd0), 4'd8);
        send_frame(KIND_CHECK, build_frame(rand_frame(), 4'd0), 4'd15);
        send_frame(KIND_CHECK, build_frame(rand_frame(), 4'd1), 4'd9);
        send_frame(KIND_CHECK, build_frame(rand_frame(), 4'd3), 4'd8);
        send_frame(KIND_CHECK, build_frame(rand_frame(), 4'd6), 4'd12);
        send_frame(KIND_CHECK, build_frame('0, 4'd15), 4'd8);
        // counter wraps from 15 to 0
        send_frame(KIND_CHECK, build_frame('1, 4'd0), 4'd15);
        send_frame(KIND_CHECK, build_frame(rand_frame(), 4'd1) ^ 64'h1, 4'd8);
        send_frame(KIND_CHECK, build_frame('1, 4'd15), 4'd8);
        send_frame(KIND_REINIT, '0, 4'd0);
        send_frame(KIND_CHECK, build_frame(rand_frame(), 4'd9), 4'd10);
        send_frame(KIND_CHECK, build_frame(rand_frame(), 4'd11), 4'd8);
        send_frame(KIND_CHECK, build_frame(rand_frame(), 4'd11), 4'd14);
        send_frame(KIND_CHECK, '1, 4'd15);
        send_frame(KIND_CHECK, build_frame(rand_frame(), 4'd12), 4'd8);
        wait_idle();

        // random phases, each under its own gap setting
        foreach (gap_values[p]) begin
            apb_write(gap_addr, 32'(gap_values[p]));
            apb_read_check(gap_addr, 32'(gap_values[p]));
            if (p == 1)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send_random(seq_cnt);
            end
            steady = 1'b0;
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        verdicts.report_leftover();
        if (verdicts.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // overall watchdog
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
